// ===== rtl/trq_pkg.sv =====
// shared types, constants and helpers for the trail ribbon quad builder
package trq_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFETIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 1'b1;

  localparam logic [30:0] MAX_LIFETIME_RESET = 31'd65536;
  localparam logic [30:0] HALF_WIDTH_RESET   = 31'd3277;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p0_z;
    logic [30:0]        p0_life;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic [30:0]        p1_life;
    logic [15:0]        base;
  } job_t;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [1:0] idx_offset(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd2;
      3'd4: r = 2'd1;
      3'd5: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/trq_queue.sv =====
// two-entry segment job queue between front and back
module trq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  trq_pkg::job_t   wr_job,
  output logic            q_full,
  input  logic            rd_en,
  output trq_pkg::job_t   rd_job,
  output logic            q_empty
);

  trq_pkg::job_t slots [trq_pkg::QUEUE_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'(trq_pkg::QUEUE_DEPTH));
  assign q_empty = (count == 2'd0);
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      if (wr_en && !rd_en) count <= count + 2'd1;
      else if (rd_en && !wr_en) count <= count - 2'd1;
    end
  end

endmodule

// ===== rtl/trq_front.sv =====
// front end: takes points, keeps the previous point and forms segment jobs
module trq_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               start_req,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        lifetime,
  output logic               job_push,
  output trq_pkg::job_t      job
);

  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] prev_z;
  logic [30:0]        prev_life;
  logic               have_previous;
  logic [15:0]        vertex_base;

  assign job_push = accept && !start_req && have_previous;

  always_comb begin
    job.p0_x    = prev_x;
    job.p0_y    = prev_y;
    job.p0_z    = prev_z;
    job.p0_life = prev_life;
    job.p1_x    = pos_x;
    job.p1_y    = pos_y;
    job.p1_z    = pos_z;
    job.p1_life = lifetime;
    job.base    = vertex_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      prev_life     <= '0;
      have_previous <= 1'b0;
      vertex_base   <= '0;
    end else if (accept) begin
      prev_x        <= pos_x;
      prev_y        <= pos_y;
      prev_z        <= pos_z;
      prev_life     <= lifetime;
      have_previous <= 1'b1;
      if (start_req) vertex_base <= '0;
      else if (have_previous) vertex_base <= vertex_base + 16'd4;
    end
  end

endmodule

// ===== rtl/trq_div.sv =====
// serial restoring divider, one quotient bit per cycle
module trq_div (
  input  logic                clk,
  input  logic                rst,
  input  trq_pkg::div_req_t   req,
  output trq_pkg::div_rsp_t   rsp
);

  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh  = {rem, quo[63]};
  assign fits    = (rem_sh >= {1'b0, den});
  assign rsp.done = done;
  assign rsp.quo  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (fits) begin
          rem <= 32'(rem_sh - {1'b0, den});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/trq_back.sv =====
// back end: side vector, alpha and the ten results of a segment
module trq_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [30:0]            max_lifetime,
  input  logic [30:0]            half_width,
  input  logic                   q_empty,
  input  trq_pkg::job_t          q_job,
  output logic                   q_pop,
  output trq_pkg::div_req_t      div_req,
  input  trq_pkg::div_rsp_t      div_rsp,
  output logic                   out_valid,
  input  logic                   out_take,
  output logic                   kind,
  output logic signed [31:0]     vert_x,
  output logic signed [31:0]     vert_y,
  output logic signed [31:0]     vert_z,
  output logic                   tex_u,
  output logic                   tex_v,
  output logic [FRAC_BITS:0]     alpha,
  output logic [15:0]            index_value,
  output logic                   last
);

  localparam logic [FRAC_BITS:0] FULL = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQR, S_SUM, S_SQRT, S_MULX, S_DXG, S_DXW, S_MULZ, S_DZG, S_DZW,
    S_A0G, S_A0W, S_A1G, S_A1W, S_EMIT
  } state_t;

  state_t state;
  trq_pkg::job_t jr;
  logic [32:0] ax;
  logic [32:0] az;
  logic        dx_neg;
  logic        dz_pos;
  logic [61:0] sqa;
  logic [61:0] sqz;
  logic [62:0] rad;
  logic [62:0] res;
  logic [62:0] sbit;
  logic [61:0] prod;
  logic signed [32:0] sx;
  logic signed [32:0] sz;
  logic [FRAC_BITS:0] a0;
  logic [FRAC_BITS:0] a1;
  logic [3:0]  k;

  logic signed [32:0] dx;
  logic signed [32:0] dz;
  logic [32:0] m;
  logic [62:0] trial;
  logic [31:0] len;
  logic [FRAC_BITS:0] asat;
  logic        load;
  logic signed [31:0] bx;
  logic signed [31:0] bz;
  logic signed [33:0] vx;
  logic signed [33:0] vz;

  assign dx    = 33'(q_job.p1_x) - 33'(q_job.p0_x);
  assign dz    = 33'(q_job.p1_z) - 33'(q_job.p0_z);
  assign m     = (ax > az) ? ax : az;
  assign trial = res + sbit;
  assign len   = res[31:0];
  assign asat  = (div_rsp.quo > 64'(FULL)) ? FULL : div_rsp.quo[FRAC_BITS:0];
  assign load  = (state == S_EMIT) && (!out_valid || out_take);
  assign q_pop = load && (k == 4'd9);

  assign bx = k[1] ? jr.p1_x : jr.p0_x;
  assign bz = k[1] ? jr.p1_z : jr.p0_z;
  assign vx = k[0] ? 34'(bx) - 34'(sx) : 34'(bx) + 34'(sx);
  assign vz = k[0] ? 34'(bz) - 34'(sz) : 34'(bz) + 34'(sz);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = {1'b0, max_lifetime};
    unique case (state) inside
      S_DXG, S_DZG: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(prod) + 64'(len >> 1);
        div_req.den   = len;
      end
      S_A0G: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(jr.p0_life) << FRAC_BITS;
      end
      S_A1G: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(jr.p1_life) << FRAC_BITS;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_take && !load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            jr     <= q_job;
            ax     <= dx[32] ? 33'(-dx) : 33'(dx);
            az     <= dz[32] ? 33'(-dz) : 33'(dz);
            dx_neg <= dx[32];
            dz_pos <= !dz[32] && (dz != '0);
            sx     <= '0;
            sz     <= '0;
            k      <= '0;
            state  <= (dx == '0 && dz == '0) ? S_A0G : S_NORM;
          end
        end
        S_NORM: begin
          if (m[32:31] != 2'b00) begin
            ax <= ax >> 1;
            az <= az >> 1;
          end else if (!m[30]) begin
            ax <= ax << 1;
            az <= az << 1;
          end else begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          sqa   <= ax[30:0] * ax[30:0];
          sqz   <= az[30:0] * az[30:0];
          state <= S_SUM;
        end
        S_SUM: begin
          rad   <= 63'(sqa) + 63'(sqz);
          res   <= '0;
          sbit  <= 63'(1) << 62;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rad >= trial) begin
            rad <= rad - trial;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) state <= S_MULX;
        end
        S_MULX: begin
          prod  <= half_width * az[30:0];
          state <= S_DXG;
        end
        S_DXG: state <= S_DXW;
        S_DXW: begin
          if (div_rsp.done) begin
            sx    <= dz_pos ? -$signed({1'b0, div_rsp.quo[31:0]})
                            : $signed({1'b0, div_rsp.quo[31:0]});
            state <= S_MULZ;
          end
        end
        S_MULZ: begin
          prod  <= half_width * ax[30:0];
          state <= S_DZG;
        end
        S_DZG: state <= S_DZW;
        S_DZW: begin
          if (div_rsp.done) begin
            sz    <= dx_neg ? -$signed({1'b0, div_rsp.quo[31:0]})
                            : $signed({1'b0, div_rsp.quo[31:0]});
            state <= S_A0G;
          end
        end
        S_A0G: begin
          if (max_lifetime == '0) begin
            a0    <= FULL;
            a1    <= FULL;
            state <= S_EMIT;
          end else begin
            state <= S_A0W;
          end
        end
        S_A0W: begin
          if (div_rsp.done) begin
            a0    <= asat;
            state <= S_A1G;
          end
        end
        S_A1G: state <= S_A1W;
        S_A1W: begin
          if (div_rsp.done) begin
            a1    <= asat;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            if (k < 4'd4) begin
              kind        <= trq_pkg::KIND_VERTEX;
              vert_x      <= trq_pkg::sat32(vx);
              vert_y      <= k[1] ? jr.p1_y : jr.p0_y;
              vert_z      <= trq_pkg::sat32(vz);
              tex_u       <= k[0];
              tex_v       <= k[1];
              alpha       <= k[1] ? a1 : a0;
              index_value <= '0;
              last        <= 1'b0;
            end else begin
              kind        <= trq_pkg::KIND_INDEX;
              vert_x      <= '0;
              vert_y      <= '0;
              vert_z      <= '0;
              tex_u       <= 1'b0;
              tex_v       <= 1'b0;
              alpha       <= '0;
              index_value <= jr.base + 16'(trq_pkg::idx_offset(3'(k - 4'd4)));
              last        <= (k == 4'd9);
            end
            k <= k + 4'd1;
            if (k == 4'd9) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/trail_ribbon_quad_builder_core.sv =====
// top level of the trail ribbon quad builder
//
// input queue side: a point transaction (start_req, pos_x/y/z, lifetime) is
// taken when push is high and full is low. the first point of a trail only
// loads the previous-point registers and gives no result.
// result queue side: the oldest result sits on the result ports while empty
// is low and is taken when pop is high. each segment gives ten results: four
// vertices, then six indices, the sixth with last set.
// a front stage forms segment jobs into a two-entry queue; the back stage
// computes the side vector and alpha with one shared serial divider
// (up to four divisions per segment), a 32-step square root and shift
// normalization. when the horizontal direction is zero, the side vector
// steps are skipped. once a segment's first result is out, the rest follow
// one result per cycle while pop is held; the next job starts after the tenth.
// when the receiver stalls, the current result holds and the back stage
// waits; the front keeps taking points until the job queue is full.
// reset (rst, synchronous) clears the trail state, the queue and output
// valid, and loads max_lifetime = 1.0 and half_width = 0.05.
// configuration: cfg_we writes cfg_data into register cfg_index; the user must do so only while idle, unenforced.
module trail_ribbon_quad_builder_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [trq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [30:0]           cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  start_req,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic [30:0]           lifetime,
  output logic                  empty,
  input  logic                  pop,
  output logic                  kind,
  output logic signed [31:0]    vert_x,
  output logic signed [31:0]    vert_y,
  output logic signed [31:0]    vert_z,
  output logic                  tex_u,
  output logic                  tex_v,
  output logic [FRAC_BITS:0]    alpha,
  output logic [15:0]           index_value,
  output logic                  last
);

  logic [30:0] max_lifetime;
  logic [30:0] half_width;
  logic accept;
  logic job_push;
  trq_pkg::job_t job_in;
  trq_pkg::job_t job_head;
  logic q_full;
  logic q_empty;
  logic q_pop;
  trq_pkg::div_req_t div_req;
  trq_pkg::div_rsp_t div_rsp;
  logic out_valid;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lifetime <= trq_pkg::MAX_LIFETIME_RESET;
      half_width   <= trq_pkg::HALF_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trq_pkg::CFG_MAX_LIFETIME: max_lifetime <= cfg_data;
        trq_pkg::CFG_HALF_WIDTH:   half_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  trq_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .start_req(start_req),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .lifetime(lifetime),
    .job_push(job_push), .job(job_in)
  );

  trq_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(job_push), .wr_job(job_in), .q_full(q_full),
    .rd_en(q_pop), .rd_job(job_head), .q_empty(q_empty)
  );

  trq_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  trq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .max_lifetime(max_lifetime), .half_width(half_width),
    .q_empty(q_empty), .q_job(job_head), .q_pop(q_pop),
    .div_req(div_req), .div_rsp(div_rsp),
    .out_valid(out_valid), .out_take(pop && out_valid),
    .kind(kind), .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
    .tex_u(tex_u), .tex_v(tex_v), .alpha(alpha), .index_value(index_value),
    .last(last)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_last_is_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (kind == trq_pkg::KIND_INDEX))
    else $error("last set on a vertex result");

  a_index_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == trq_pkg::KIND_INDEX) |-> (vert_x == '0 && alpha == '0))
    else $error("index result carries vertex data");

  a_vertex_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == trq_pkg::KIND_VERTEX) |-> (index_value == '0 && !last))
    else $error("vertex result carries index data");

endmodule

// ===== tb/trail_ribbon_quad_builder_core_tb.sv =====
// testbench for the trail ribbon quad builder: directed table, then random trails, checked by a predictor
`timescale 1ns / 100ps

module trail_ribbon_quad_builder_core_tb;

  localparam int FRAC = 16;
  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 1000;
  localparam logic [FRAC:0] ALPHA_ONE = (FRAC+1)'(1) << FRAC;

  typedef struct {
    logic               kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               u;
    logic               v;
    logic [FRAC:0]      alpha;
    logic [15:0]        idx;
    logic               last;
  } ribbon_out_t;

  typedef struct {
    logic               start;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        life;
    logic               typed;
    logic [FRAC:0]      alpha_typed;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [trq_pkg::CFG_IDX_W-1:0] cfg_index = trq_pkg::CFG_MAX_LIFETIME;
  logic [30:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic start_req = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [30:0] lifetime = '0;
  logic empty;
  logic pop = 1'b0;
  logic kind, tex_u, tex_v, last;
  logic signed [31:0] vert_x, vert_y, vert_z;
  logic [FRAC:0] alpha;
  logic [15:0] index_value;

  trail_ribbon_quad_builder_core #(.FRAC_BITS(FRAC)) DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [30:0] max_life_q = trq_pkg::MAX_LIFETIME_RESET;
  logic [30:0] half_w_q = trq_pkg::HALF_WIDTH_RESET;
  logic signed [31:0] last_x, last_y, last_z;
  logic [30:0] last_life;
  logic have_last = 1'b0;
  logic [15:0] base_q = '0;

  ribbon_out_t pending_q[$];
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [FRAC:0] alpha_for(logic [30:0] life);
    logic [63:0] a;
    if (max_life_q == 0) return ALPHA_ONE;
    a = ({33'd0, life} << FRAC) / max_life_q;
    return (a > (64'd1 << FRAC)) ? ALPHA_ONE : a[FRAC:0];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic add_vertex(logic signed [31:0] x, y, z, logic u, v, logic [FRAC:0] a);
    ribbon_out_t r;
    r.kind = trq_pkg::KIND_VERTEX; r.x = x; r.y = y; r.z = z; r.u = u; r.v = v;
    r.alpha = a; r.idx = '0; r.last = 1'b0;
    pending_q = {pending_q, r};
  endtask

  task automatic predict_segment(logic st, logic signed [31:0] px, py, pz, logic [30:0] life);
    longint dx, dz, sx, sz;
    logic [63:0] ax, az, m, len, mx, mz;
    logic [FRAC:0] a0, a1;
    ribbon_out_t r;
    logic [1:0] offs[6];
    offs = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd3};
    if (st || !have_last) begin
      if (st) base_q = '0;
      last_x = px; last_y = py; last_z = pz; last_life = life; have_last = 1'b1;
      return;
    end
    dx = longint'(px) - longint'(last_x);
    dz = longint'(pz) - longint'(last_z);
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    m = ax > az ? ax : az;
    sx = 0; sz = 0;
    if (m != 0) begin
      while (m >= (64'd1 << 31)) begin ax >>= 1; az >>= 1; m >>= 1; end
      while (m < (64'd1 << 30)) begin ax <<= 1; az <<= 1; m <<= 1; end
      len = root64(ax * ax + az * az);
      mx = (64'(half_w_q) * az + len / 2) / len;
      mz = (64'(half_w_q) * ax + len / 2) / len;
      sx = dz > 0 ? -longint'(mx) : longint'(mx);
      sz = dx < 0 ? -longint'(mz) : longint'(mz);
    end
    a0 = alpha_for(last_life);
    a1 = alpha_for(life);
    add_vertex(clamp32(last_x + sx), last_y, clamp32(last_z + sz), 1'b0, 1'b0, a0);
    add_vertex(clamp32(last_x - sx), last_y, clamp32(last_z - sz), 1'b1, 1'b0, a0);
    add_vertex(clamp32(px + sx), py, clamp32(pz + sz), 1'b0, 1'b1, a1);
    add_vertex(clamp32(px - sx), py, clamp32(pz - sz), 1'b1, 1'b1, a1);
    for (int k = 0; k < 6; k++) begin
      r.kind = trq_pkg::KIND_INDEX; r.x = '0; r.y = '0; r.z = '0;
      r.u = 1'b0; r.v = 1'b0; r.alpha = '0;
      r.idx = base_q + offs[k]; r.last = (k == 5);
      pending_q = {pending_q, r};
    end
    base_q += 16'd4;
    last_x = px; last_y = py; last_z = pz; last_life = life;
  endtask

  task automatic send_point(logic st, logic signed [31:0] x, y, z, logic [30:0] life);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    start_req <= st; pos_x <= x; pos_y <= y; pos_z <= z; lifetime <= life;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_segment(st, x, y, z, life);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain_all();
    push <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [trq_pkg::CFG_IDX_W-1:0] i, logic [30:0] d);
    cfg_we <= 1'b1; cfg_index <= i; cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (i == trq_pkg::CFG_MAX_LIFETIME) max_life_q = d; else half_w_q = d;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff - $urandom_range(3);
      1: return 32'sh80000000 + $urandom_range(3);
      2: return $urandom;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  // receiver
  always @(negedge clk) begin
    if (rst || recv_hold) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    ribbon_out_t e;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transaction kind=%0b idx=%0d", $realtime, kind, index_value);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (kind !== e.kind || vert_x !== e.x || vert_y !== e.y || vert_z !== e.z ||
            tex_u !== e.u || tex_v !== e.v || alpha !== e.alpha ||
            index_value !== e.idx || last !== e.last) begin
          $display("%0t: mismatch expected k=%0b x=%0d y=%0d z=%0d u=%0b v=%0b a=%0d i=%0d l=%0b",
                   $realtime, e.kind, e.x, e.y, e.z, e.u, e.v, e.alpha, e.idx, e.last);
          $display("%0t:          actual k=%0b x=%0d y=%0d z=%0d u=%0b v=%0b a=%0d i=%0d l=%0b",
                   $realtime, kind, vert_x, vert_y, vert_z, tex_u, tex_v, alpha,
                   index_value, last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst || (pending_q.size() == 0 && !stim_done))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("Some tests failed");
      $finish;
    end
  end

  point_row_t dir_rows[$];

  function automatic point_row_t mk(logic st, logic signed [31:0] x, y, z, logic [30:0] l,
                                    logic t = 1'b0, logic [FRAC:0] a = '0);
    point_row_t r;
    r.start = st; r.x = x; r.y = y; r.z = z; r.life = l; r.typed = t; r.alpha_typed = a;
    return r;
  endfunction

  initial begin
    int hold_len;
    dir_rows = '{
      mk(1'b1, 0, 0, 0, 31'd65536),
      mk(1'b0, 32'sd65536, 0, 0, 31'd32768, 1'b1, 17'd32768),
      mk(1'b0, 32'sd65536, 32'sd100, 0, 31'd0, 1'b1, 17'd0),
      mk(1'b0, 32'sd65536, 0, 32'sd65536, 31'h7fffffff, 1'b1, 17'd65536),
      mk(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'd65536),
      mk(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd1),
      mk(1'b0, 32'sh7fffffff, 0, 32'sh80000000, 31'd100),
      mk(1'b0, 32'sh7fffffff, 0, 32'sh80000000, 31'd200),
      mk(1'b1, 32'sd5, 32'sd6, 32'sd7, 31'd65535),
      mk(1'b0, 32'sd4, 32'sd6, 32'sd7, 31'd65537),
      mk(1'b0, 32'sd4, 32'sd6, 32'sd8, 31'd12345),
      mk(1'b0, -32'sd1, 32'sh55555555, 32'shaaaaaaaa, 31'h2aaaaaaa),
      mk(1'b1, 32'shaaaaaaaa, 32'sh55555555, 32'sh55555555, 31'h55555555),
      mk(1'b0, 32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 31'h2aaaaaaa)
    };
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 11; recv_idle_pct = 62;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed && dir_rows[i].alpha_typed !== alpha_for(dir_rows[i].life)) begin
        $display("%0t: table alpha expected %0d actual %0d", $realtime,
                 dir_rows[i].alpha_typed, alpha_for(dir_rows[i].life));
        errors++;
      end
      send_point(dir_rows[i].start, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                 dir_rows[i].life);
    end
    drain_all();
    write_reg(trq_pkg::CFG_MAX_LIFETIME, 31'd1);
    write_reg(trq_pkg::CFG_HALF_WIDTH, 31'h7fffffff);
    send_point(1'b1, 0, 0, 0, 31'h7fffffff);
    send_point(1'b0, 32'sd3, 0, -32'sd4, 31'd0);
    send_point(1'b0, 32'sh7fffff00, 0, 32'sh7fffff00, 31'd1);
    drain_all();
    write_reg(trq_pkg::CFG_HALF_WIDTH, 31'd0);
    write_reg(trq_pkg::CFG_MAX_LIFETIME, 31'h7fffffff);
    send_point(1'b0, -32'sd9, 32'sd9, 32'sd9, 31'h7fffffff);
    drain_all();

    // long stall while the sender keeps offering
    recv_hold = 1'b1;
    fork
      begin
        hold_len = 3000;
        repeat (hold_len) @(negedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_point(i == 0, rnd_coord(), rnd_coord(), rnd_coord(), 31'($urandom));
    join
    drain_all();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 11 : 0;
      case (phase)
        0: begin write_reg(trq_pkg::CFG_MAX_LIFETIME, 31'($urandom_range(1, 200000)));
                 write_reg(trq_pkg::CFG_HALF_WIDTH, 31'($urandom_range(0, 1000000))); end
        1: begin write_reg(trq_pkg::CFG_MAX_LIFETIME, 31'($urandom));
                 write_reg(trq_pkg::CFG_HALF_WIDTH, 31'($urandom)); end
        default: begin write_reg(trq_pkg::CFG_MAX_LIFETIME, trq_pkg::MAX_LIFETIME_RESET);
                 write_reg(trq_pkg::CFG_HALF_WIDTH, trq_pkg::HALF_WIDTH_RESET); end
      endcase
      for (int i = 0; i < 62; i++) begin
        if ($urandom_range(99) < 8)
          send_point(1'b1, rnd_coord(), rnd_coord(), rnd_coord(), 31'($urandom));
        else if ($urandom_range(99) < 10)
          send_point(1'b0, last_x, rnd_coord(), last_z, 31'($urandom));
        else
          send_point(1'b0, rnd_coord(), rnd_coord(), rnd_coord(),
                     31'($urandom_range(1) ? $urandom : $urandom_range(0, 140000)));
      end
      drain_all();
    end
    stim_done = 1'b1;

    $display("sent %0d points, checked %0d results over directed, stall and random phases",
             points_sent, results_seen);
    if (errors == 0 && pending_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
